// ----- rtl/core/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants for the rotation matrix to quaternion pipeline
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FIELD_W = 31;
    localparam int CAND_W  = 33;
    localparam int MAG_W   = 32;
    localparam int REM_W   = 60;
    localparam int ROOT_W  = 30;
    localparam int S_W     = 31;
    localparam int DIV_W   = 32;
    localparam int NUM_W   = 61;
    localparam int QUO_W   = 31;

    localparam logic signed [CAND_W-1:0] Q_ONE = 33'sd536870912;
    localparam logic [QUO_W-1:0]         Q_MAX = 31'd536870912;

    localparam logic [1:0] BR_W = 2'd0;
    localparam logic [1:0] BR_X = 2'd1;
    localparam logic [1:0] BR_Y = 2'd2;
    localparam logic [1:0] BR_Z = 2'd3;

    typedef logic [MAG_W-1:0] t_mag;
    typedef logic [QUO_W-1:0] t_quo;
    typedef logic [NUM_W-1:0] t_num;

    typedef struct packed {
        logic       ok;
        logic [1:0] br;
        logic       flip;
        logic [2:0] neg;
    } t_ctx;

    typedef struct packed {
        logic              valid;
        t_ctx              ctx;
        t_mag [2:0]        mag;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    typedef struct packed {
        logic             valid;
        t_ctx             ctx;
        logic [S_W-1:0]   s;
        logic [DIV_W-1:0] d;
        t_num [2:0]       nrem;
        t_quo [2:0]       q;
        logic [2:0]       sat;
    } t_dv;

endpackage

// ----- rtl/core/rmq_front.sv -----
// ----------------------------------------------------------------------------
// rmq_front
// candidate sums, branch pick and numerator selection, one register stage
// ----------------------------------------------------------------------------
module rmq_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [rmq_pkg::FIELD_W-1:0]    i_m [9],
    output rmq_pkg::t_sq                          o_sq
);
    import rmq_pkg::*;

    logic signed [CAND_W-1:0] c0, c1, c2, c3;
    logic signed [CAND_W-1:0] best;
    logic [1:0]               br;
    logic                     ok;
    logic signed [MAG_W-1:0]  dx, dy, dz, sxy, sxz, syz;
    logic signed [MAG_W-1:0]  d0;
    logic signed [MAG_W-1:0]  ln [3];
    t_sq                      n_sq;
    t_sq                      r_sq;

    function automatic logic signed [CAND_W-1:0] ext(input logic signed [FIELD_W-1:0] v);
        ext = CAND_W'(v);
    endfunction

    function automatic logic signed [MAG_W-1:0] ex2(input logic signed [FIELD_W-1:0] v);
        ex2 = MAG_W'(v);
    endfunction

    always_comb begin
        c0 = Q_ONE + ext(i_m[0]) + ext(i_m[4]) + ext(i_m[8]);
        c1 = Q_ONE + ext(i_m[0]) - ext(i_m[4]) - ext(i_m[8]);
        c2 = Q_ONE - ext(i_m[0]) + ext(i_m[4]) - ext(i_m[8]);
        c3 = Q_ONE - ext(i_m[0]) - ext(i_m[4]) + ext(i_m[8]);
        best = '0;
        br   = BR_W;
        ok   = 1'b0;
        if (c0 > best) begin best = c0; br = BR_W; ok = 1'b1; end
        if (c1 > best) begin best = c1; br = BR_X; ok = 1'b1; end
        if (c2 > best) begin best = c2; br = BR_Y; ok = 1'b1; end
        if (c3 > best) begin best = c3; br = BR_Z; ok = 1'b1; end

        dx  = ex2(i_m[7]) - ex2(i_m[5]);
        dy  = ex2(i_m[2]) - ex2(i_m[6]);
        dz  = ex2(i_m[3]) - ex2(i_m[1]);
        sxy = ex2(i_m[1]) + ex2(i_m[3]);
        sxz = ex2(i_m[2]) + ex2(i_m[6]);
        syz = ex2(i_m[5]) + ex2(i_m[7]);

        // lanes hold the three non-chosen components in index order
        unique case (br)
            BR_W: begin d0 = '0; ln[0] = dx; ln[1] = dy;  ln[2] = dz;  end
            BR_X: begin d0 = dx; ln[0] = dx; ln[1] = sxy; ln[2] = sxz; end
            BR_Y: begin d0 = dy; ln[0] = dy; ln[1] = sxy; ln[2] = syz; end
            default: begin d0 = dz; ln[0] = dz; ln[1] = sxz; ln[2] = syz; end
        endcase

        n_sq.valid    = i_valid;
        n_sq.ctx.ok   = ok;
        n_sq.ctx.br   = br;
        n_sq.ctx.flip = (br != BR_W) && d0[MAG_W-1];
        for (int j = 0; j < 3; j++) begin
            n_sq.ctx.neg[j] = ln[j][MAG_W-1];
            n_sq.mag[j]     = ln[j][MAG_W-1] ? MAG_W'(-ln[j]) : MAG_W'(ln[j]);
        end
        n_sq.rem  = REM_W'({best[31:0], 27'd0});
        n_sq.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.valid <= 1'b0;
        end else if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

// ----- rtl/core/rmq_sqrt_step.sv -----
// ----------------------------------------------------------------------------
// rmq_sqrt_step
// one root bit of the digit-by-digit square root, registered
// ----------------------------------------------------------------------------
module rmq_sqrt_step #(
    parameter int K = 29
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  rmq_pkg::t_sq  i_sq,
    output rmq_pkg::t_sq  o_sq
);
    import rmq_pkg::*;

    logic [61:0] trial;
    t_sq         n_sq;
    t_sq         r_sq;

    always_comb begin
        trial = (62'(i_sq.root) << (K + 1)) + (62'(1) << (2 * K));
        n_sq  = i_sq;
        if (62'(i_sq.rem) >= trial) begin
            n_sq.rem  = i_sq.rem - trial[REM_W-1:0];
            n_sq.root = i_sq.root | (ROOT_W'(1) << K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.valid <= 1'b0;
        end else if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

// ----- rtl/core/rmq_div_prep.sv -----
// ----------------------------------------------------------------------------
// rmq_div_prep
// rounds the root and sets up the three rounded divisions
// ----------------------------------------------------------------------------
module rmq_div_prep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  rmq_pkg::t_sq  i_sq,
    output rmq_pkg::t_dv  o_dv
);
    import rmq_pkg::*;

    logic [S_W-1:0] s;
    t_dv            n_dv;
    t_dv            r_dv;

    always_comb begin
        s = S_W'(i_sq.root) + S_W'(i_sq.rem > REM_W'(i_sq.root));
        n_dv.valid = i_sq.valid;
        n_dv.ctx   = i_sq.ctx;
        n_dv.s     = s;
        n_dv.d     = {s, 1'b0};
        for (int j = 0; j < 3; j++) begin
            // numerator 2n + s, divisor 2s gives round half away from zero
            n_dv.nrem[j] = (NUM_W'(i_sq.mag[j]) << 28) + NUM_W'(s);
            n_dv.q[j]    = '0;
            n_dv.sat[j]  = 63'(n_dv.nrem[j]) >= (63'({s, 1'b0}) << 31);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv.valid <= 1'b0;
        end else if (i_en) begin
            r_dv <= n_dv;
        end
    end

    assign o_dv = r_dv;

endmodule

// ----- rtl/core/rmq_div_step.sv -----
// ----------------------------------------------------------------------------
// rmq_div_step
// one quotient bit of restoring division for all three lanes, registered
// ----------------------------------------------------------------------------
module rmq_div_step #(
    parameter int K = 30
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  rmq_pkg::t_dv  i_dv,
    output rmq_pkg::t_dv  o_dv
);
    import rmq_pkg::*;

    logic [62:0] dsh;
    t_dv         n_dv;
    t_dv         r_dv;

    always_comb begin
        dsh  = 63'(i_dv.d) << K;
        n_dv = i_dv;
        for (int j = 0; j < 3; j++) begin
            if (63'(i_dv.nrem[j]) >= dsh) begin
                n_dv.nrem[j] = i_dv.nrem[j] - dsh[NUM_W-1:0];
                n_dv.q[j]    = i_dv.q[j] | (QUO_W'(1) << K);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv.valid <= 1'b0;
        end else if (i_en) begin
            r_dv <= n_dv;
        end
    end

    assign o_dv = r_dv;

endmodule

// ----- rtl/core/rotation_matrix_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix (Q2.29) to unit quaternion by the largest-diagonal method
// ----------------------------------------------------------------------------
// pipeline: front stage, square root stages, divide setup, quotient stages, then the output register
// throughput: one matrix per cycle while no stall is held, set by the bit-per-stage sqrt and divider
// stalls freeze the whole pipeline; an output register holds the last result
// reset (synchronous, active low) clears every stage valid bit
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [rmq_pkg::FIELD_W-1:0]  i_m00,
    input  logic signed [rmq_pkg::FIELD_W-1:0]  i_m01,
    input  logic signed [rmq_pkg::FIELD_W-1:0]  i_m02,
    input  logic signed [rmq_pkg::FIELD_W-1:0]  i_m10,
    input  logic signed [rmq_pkg::FIELD_W-1:0]  i_m11,
    input  logic signed [rmq_pkg::FIELD_W-1:0]  i_m12,
    input  logic signed [rmq_pkg::FIELD_W-1:0]  i_m20,
    input  logic signed [rmq_pkg::FIELD_W-1:0]  i_m21,
    input  logic signed [rmq_pkg::FIELD_W-1:0]  i_m22,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [rmq_pkg::FIELD_W-1:0]  o_quat_w,
    output logic signed [rmq_pkg::FIELD_W-1:0]  o_quat_x,
    output logic signed [rmq_pkg::FIELD_W-1:0]  o_quat_y,
    output logic signed [rmq_pkg::FIELD_W-1:0]  o_quat_z,
    output logic [1:0]                          o_branch,
    output logic                                o_ok
);
    import rmq_pkg::*;

    // every stage advances together unless the output is held by the sink
    logic en;

    logic signed [FIELD_W-1:0] m_in [9];
    t_sq sq_bus [0:ROOT_W];
    t_dv dv_bus [0:QUO_W];

    logic [QUO_W-1:0]          mag4 [4];
    logic                      neg4 [4];
    logic signed [FIELD_W-1:0] n_q  [4];

    logic                      r_valid;
    logic signed [FIELD_W-1:0] r_q [4];
    logic [1:0]                r_branch;
    logic                      r_ok;

    assign en      = !(r_valid && i_stall);
    assign o_stall = !en;

    assign m_in[0] = i_m00;
    assign m_in[1] = i_m01;
    assign m_in[2] = i_m02;
    assign m_in[3] = i_m10;
    assign m_in[4] = i_m11;
    assign m_in[5] = i_m12;
    assign m_in[6] = i_m20;
    assign m_in[7] = i_m21;
    assign m_in[8] = i_m22;

    // candidates, branch and numerators
    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_m     (m_in),
        .o_sq    (sq_bus[0])
    );

    // square root, one result bit per stage, msb first
    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        rmq_sqrt_step #(.K(ROOT_W - 1 - g)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_sq    (sq_bus[g]),
            .o_sq    (sq_bus[g+1])
        );
    end

    // rounding of the root and setup of the three divisions
    rmq_div_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_sq    (sq_bus[ROOT_W]),
        .o_dv    (dv_bus[0])
    );

    // restoring division, one quotient bit per stage for all three lanes
    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        rmq_div_step #(.K(QUO_W - 1 - g)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_dv    (dv_bus[g]),
            .o_dv    (dv_bus[g+1])
        );
    end

    // final assembly: saturate, place chosen component, apply signs, zero all parts when no candidate is positive
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (2'(i) == dv_bus[QUO_W].ctx.br) begin
                mag4[i] = (dv_bus[QUO_W].s > Q_MAX) ? Q_MAX : dv_bus[QUO_W].s;
                neg4[i] = dv_bus[QUO_W].ctx.flip;
            end else if (2'(i) < dv_bus[QUO_W].ctx.br) begin
                mag4[i] = (dv_bus[QUO_W].sat[i] || dv_bus[QUO_W].q[i] > Q_MAX)
                        ? Q_MAX : dv_bus[QUO_W].q[i];
                neg4[i] = dv_bus[QUO_W].ctx.neg[i] ^ dv_bus[QUO_W].ctx.flip;
            end else begin
                mag4[i] = (dv_bus[QUO_W].sat[i-1] || dv_bus[QUO_W].q[i-1] > Q_MAX)
                        ? Q_MAX : dv_bus[QUO_W].q[i-1];
                neg4[i] = dv_bus[QUO_W].ctx.neg[i-1] ^ dv_bus[QUO_W].ctx.flip;
            end
            if (!dv_bus[QUO_W].ctx.ok) begin
                n_q[i] = '0;
            end else if (neg4[i]) begin
                n_q[i] = -$signed(mag4[i]);
            end else begin
                n_q[i] = $signed(mag4[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid  <= dv_bus[QUO_W].valid;
            r_q      <= n_q;
            r_branch <= dv_bus[QUO_W].ctx.ok ? dv_bus[QUO_W].ctx.br : BR_W;
            r_ok     <= dv_bus[QUO_W].ctx.ok;
        end
    end

    assign o_valid  = r_valid;
    assign o_quat_w = r_q[0];
    assign o_quat_x = r_q[1];
    assign o_quat_y = r_q[2];
    assign o_quat_z = r_q[3];
    assign o_branch = r_branch;
    assign o_ok     = r_ok;

    // no positive candidate gives an all-zero quaternion on branch w
    a_not_ok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_quat_w == '0 && o_quat_x == '0 &&
                                o_quat_y == '0 && o_quat_z == '0 && o_branch == BR_W))
        else $error("invalid result not zeroed");

    // scalar part is never negative
    a_w_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_quat_w[FIELD_W-1])
        else $error("negative w");

    // stall back-pressure only when a result is held
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("stall mismatch");

    // x stays inside the saturation range and w stays at or below its top
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat_x <= 31'sd536870912 && o_quat_x >= -31'sd536870912 &&
                     o_quat_w <= 31'sd536870912))
        else $error("result out of range");

endmodule
